// File: hw/rtl/nhpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhpf_pkg
// Shared types and constants of the next-hop packet forwarder.
// ----------------------------------------------------------------------------
package nhpf_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int TBL_ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENTRY_W      = 16;

    localparam int IN_TDATA_W   = 64;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 32;
    localparam int OUT_TUSER_W  = 3;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [7:0] OWN_ADDRESS_RST = 8'd1;
    localparam logic [7:0] PORT_LIMIT_RST  = 8'd16;
    localparam logic [7:0] BCAST_ADDR      = 8'd0;

    typedef enum logic [IN_TUSER_W-1:0] {
        OP_SEND  = 2'd0,
        OP_RECV  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [OUT_TUSER_W-1:0] {
        ACT_TRANSMIT = 3'd0,
        ACT_DELIVER  = 3'd1,
        ACT_NO_ROUTE = 3'd2,
        ACT_BAD_PORT = 3'd3,
        ACT_OWN      = 3'd4,
        ACT_TTL      = 3'd5,
        ACT_NOT_US   = 3'd6,
        ACT_WRITTEN  = 3'd7
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OWN_ADDRESS = 2'd0,
        REG_ROUTE_READY = 2'd1,
        REG_PORT_LIMIT  = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [7:0] own_address;
        logic       route_ready;
        logic [7:0] port_limit;
    } cfg_t;

    // Header fields kept for the decision stage
    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] dest_node;
        logic [7:0] orig_node;
        logic [7:0] next_node;
        logic [7:0] port;
        logic [7:0] ttl;
        logic       in_range;   // destination falls inside the table
    } hdr_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] out_receiver;
        logic [7:0] out_snd_addr;
        logic       rewrite_sender;
        logic [7:0] out_ttl;
    } result_t;

endpackage

// File: hw/rtl/next_hop_packet_forwarder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_hop_packet_forwarder_unit
// Mesh-node network layer: route table lookup, forward/deliver/drop decision.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------
//  s_      | in        | tvalid/tready      | tuser opcode, tdata header+entry
//  m_      | out       | tvalid/tready      | tuser action, tdata result fields
//  cfg_    | in        | cfg_we (no ready)  | cfg_index, cfg_wdata
//
//  One item per cycle while m_tready is high. The route table RAM read is
//  registered at the input transfer, the decision lands in the result register.
//  Reset clears the per-entry valid bits at once; no clearing pass is needed.
//  With m_tready low the result holds, the header stage fills, then s_tready
//  drops until the result is taken.
// ----------------------------------------------------------------------------
module next_hop_packet_forwarder_unit (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // destination, origin, next receiver, port, ttl, entry_index, entry_dst,
    // entry_next_hop
    input  logic [nhpf_pkg::IN_TDATA_W-1:0]    s_tdata,
    // opcode
    input  logic [nhpf_pkg::IN_TUSER_W-1:0]    s_tuser,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_receiver, out_snd_addr, rewrite_sender, out_ttl, zero pad
    output logic [nhpf_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // action
    output logic [nhpf_pkg::OUT_TUSER_W-1:0]   m_tuser,

    input  logic                               cfg_we,
    input  logic [nhpf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [nhpf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    nhpf_pkg::cfg_t    cfg_reg;
    nhpf_pkg::hdr_t    in_hdr;
    nhpf_pkg::hdr_t    hdr_reg;
    nhpf_pkg::result_t result;
    nhpf_pkg::result_t result_reg;

    logic [7:0] entry_index;
    logic [7:0] entry_dst;
    logic [7:0] entry_next_hop;

    logic                              hdr_valid_reg;
    logic                              hdr_valid_next;
    logic                              m_valid_reg;
    logic                              m_valid_next;
    logic                              advance;
    logic                              accept;
    logic                              tbl_we;
    logic                              widx_in_range;
    logic [nhpf_pkg::TBL_ADDR_W-1:0]   tbl_waddr;
    logic [nhpf_pkg::TBL_ADDR_W-1:0]   tbl_raddr;
    logic [nhpf_pkg::TABLE_DEPTH-1:0]  tbl_valid_reg;
    logic                              ent_valid_reg;
    logic [nhpf_pkg::ENTRY_W-1:0]      ram_rdata;
    logic [nhpf_pkg::ENTRY_W-1:0]      entry;

    // input unpacking
    assign in_hdr.opcode    = nhpf_pkg::opcode_t'(s_tuser);
    assign in_hdr.dest_node = s_tdata[7:0];
    assign in_hdr.orig_node = s_tdata[15:8];
    assign in_hdr.next_node = s_tdata[23:16];
    assign in_hdr.port      = s_tdata[31:24];
    assign in_hdr.ttl       = s_tdata[39:32];
    assign in_hdr.in_range  = ({1'b0, s_tdata[7:0]} < 9'(nhpf_pkg::TABLE_DEPTH));
    assign entry_index      = s_tdata[47:40];
    assign entry_dst        = s_tdata[55:48];
    assign entry_next_hop   = s_tdata[63:56];

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !hdr_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign widx_in_range = ({1'b0, entry_index} < 9'(nhpf_pkg::TABLE_DEPTH));
    assign tbl_we    = accept && (in_hdr.opcode == nhpf_pkg::OP_WRITE) && widx_in_range;
    assign tbl_waddr = entry_index[nhpf_pkg::TBL_ADDR_W-1:0];
    assign tbl_raddr = in_hdr.dest_node[nhpf_pkg::TBL_ADDR_W-1:0];

    // Write and lookup of one transfer share the edge; a write is seen by the
    // next transfer's lookup.
    nhpf_ram #(
        .WIDTH (nhpf_pkg::ENTRY_W),
        .DEPTH (nhpf_pkg::TABLE_DEPTH)
    ) u_route_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata ({entry_dst, entry_next_hop}),
        .re    (accept),
        .raddr (tbl_raddr),
        .rdata (ram_rdata)
    );

    // never-written entries read as zero
    assign entry = ent_valid_reg ? ram_rdata : '0;

    nhpf_decide u_decide (
        .hdr       (hdr_reg),
        .cfg       (cfg_reg),
        .entry_dst (entry[15:8]),
        .entry_hop (entry[7:0]),
        .result    (result)
    );

    always_comb begin
        hdr_valid_next = hdr_valid_reg;
        if (accept) begin
            hdr_valid_next = 1'b1;
        end else if (advance) begin
            hdr_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = hdr_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            tbl_valid_reg <= '0;
            cfg_reg.own_address <= nhpf_pkg::OWN_ADDRESS_RST;
            cfg_reg.route_ready <= 1'b0;
            cfg_reg.port_limit  <= nhpf_pkg::PORT_LIMIT_RST;
        end else begin
            hdr_valid_reg <= hdr_valid_next;
            m_valid_reg   <= m_valid_next;
            if (tbl_we) begin
                tbl_valid_reg[tbl_waddr] <= 1'b1;
            end
            if (cfg_we) begin
                case (nhpf_pkg::reg_index_t'(cfg_index))
                    nhpf_pkg::REG_OWN_ADDRESS: cfg_reg.own_address <= cfg_wdata;
                    nhpf_pkg::REG_ROUTE_READY: cfg_reg.route_ready <= cfg_wdata[0];
                    nhpf_pkg::REG_PORT_LIMIT:  cfg_reg.port_limit  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hdr_reg       <= in_hdr;
            ent_valid_reg <= tbl_valid_reg[tbl_raddr];
        end
        if (advance && hdr_valid_reg) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = result_reg.action;
    assign m_tdata  = {7'd0, result_reg.out_ttl, result_reg.rewrite_sender,
                       result_reg.out_snd_addr, result_reg.out_receiver};

endmodule

// File: hw/rtl/nhpf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhpf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nhpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/nhpf_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhpf_decide
// Forwarding decision for one header and its looked-up route entry.
// ----------------------------------------------------------------------------
module nhpf_decide (
    input  nhpf_pkg::hdr_t    hdr,
    input  nhpf_pkg::cfg_t    cfg,
    input  logic [7:0]        entry_dst,
    input  logic [7:0]        entry_hop,
    output nhpf_pkg::result_t result
);

    logic hit;

    assign hit = cfg.route_ready && hdr.in_range && (entry_dst == hdr.dest_node);

    always_comb begin
        result = '0;
        case (hdr.opcode)
            nhpf_pkg::OP_SEND: begin
                if (hdr.dest_node == nhpf_pkg::BCAST_ADDR || hit) begin
                    result.action         = nhpf_pkg::ACT_TRANSMIT;
                    result.out_receiver   = (hdr.dest_node == nhpf_pkg::BCAST_ADDR)
                                            ? nhpf_pkg::BCAST_ADDR : entry_hop;
                    result.out_snd_addr   = cfg.own_address;
                    result.rewrite_sender = 1'b1;
                    result.out_ttl        = hdr.ttl;
                end else begin
                    result.action = nhpf_pkg::ACT_NO_ROUTE;
                end
            end
            nhpf_pkg::OP_RECV: begin
                if (hdr.port >= cfg.port_limit) begin
                    result.action = nhpf_pkg::ACT_BAD_PORT;
                end else if (hdr.orig_node == cfg.own_address) begin
                    result.action = nhpf_pkg::ACT_OWN;
                end else if (hdr.dest_node == cfg.own_address ||
                             hdr.dest_node == nhpf_pkg::BCAST_ADDR) begin
                    result.action = nhpf_pkg::ACT_DELIVER;
                end else if (hdr.next_node == cfg.own_address) begin
                    // relay through this node
                    if (hdr.ttl <= 8'd1) begin
                        result.action = nhpf_pkg::ACT_TTL;
                    end else if (hit) begin
                        result.action       = nhpf_pkg::ACT_TRANSMIT;
                        result.out_receiver = entry_hop;
                        result.out_ttl      = hdr.ttl - 8'd1;
                    end else begin
                        result.action = nhpf_pkg::ACT_NO_ROUTE;
                    end
                end else begin
                    result.action = nhpf_pkg::ACT_NOT_US;
                end
            end
            nhpf_pkg::OP_WRITE: begin
                result.action = nhpf_pkg::ACT_WRITTEN;
            end
            default: begin
                result.action = nhpf_pkg::ACT_NOT_US;
            end
        endcase
    end

endmodule

// File: hw/rtl/nhpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhpf_checker
// Port-level checks of the forwarder, bound to the top level.
// ----------------------------------------------------------------------------
module nhpf_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [nhpf_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic [nhpf_pkg::OUT_TUSER_W-1:0]   m_tuser
);

    // result register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // only a transmit carries header fields
    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != nhpf_pkg::ACT_TRANSMIT) |-> (m_tdata == '0))
        else $error("non-transmit result with nonzero fields");

    // forwarded packets keep their sender: no sender address without rewrite
    a_sender_rewrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[16] |-> (m_tdata[15:8] == 8'd0))
        else $error("sender address without rewrite flag");

endmodule

bind next_hop_packet_forwarder_unit nhpf_checker u_nhpf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: test/forwarding_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forwarding_checker
// Watches the packet and result channels of the next-hop forwarder, keeps its
// own route table and register copies, works out the decision for every
// accepted packet and compares each result transfer against the oldest one.
// ----------------------------------------------------------------------------
module forwarding_checker
    import nhpf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    input  logic [IN_TUSER_W-1:0]   s_tuser,

    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OUT_TDATA_W-1:0]  m_tdata,
    input  logic [OUT_TUSER_W-1:0]  m_tuser,

    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,

    output int                      mismatch_count,
    output int                      decisions_pending
);

    logic [7:0] own_address;
    logic       route_ready;
    logic [7:0] port_limit;

    logic [7:0] route_dst [TABLE_DEPTH];
    logic [7:0] route_hop [TABLE_DEPTH];

    result_t    expected_decisions [$];

    function automatic logic find_next_hop(input logic [7:0] dst, output logic [7:0] hop);
        hop = '0;
        if (!route_ready || int'(dst) >= TABLE_DEPTH)
            return 1'b0;
        if (route_dst[dst] != dst)
            return 1'b0;
        hop = route_hop[dst];
        return 1'b1;
    endfunction

    // Decision for one packet; a table write also updates the local table.
    function automatic result_t forward_item(input opcode_t op, input logic [IN_TDATA_W-1:0] hdr);
        logic [7:0] dst, src, rcv, port, ttl, eidx, edst, ehop, hop;
        result_t    r;
        {ehop, edst, eidx, ttl, port, rcv, src, dst} = hdr;
        r = '0;
        r.action = ACT_NOT_US;
        case (op)
            OP_SEND: begin
                if (dst == BCAST_ADDR || find_next_hop(dst, hop)) begin
                    r.action         = ACT_TRANSMIT;
                    r.out_receiver   = (dst == BCAST_ADDR) ? BCAST_ADDR : hop;
                    r.out_snd_addr   = own_address;
                    r.rewrite_sender = 1'b1;
                    r.out_ttl        = ttl;
                end else begin
                    r.action = ACT_NO_ROUTE;
                end
            end
            OP_RECV: begin
                if (port >= port_limit)
                    r.action = ACT_BAD_PORT;
                else if (src == own_address)
                    r.action = ACT_OWN;
                else if (dst == own_address || dst == BCAST_ADDR)
                    r.action = ACT_DELIVER;
                else if (rcv == own_address) begin
                    if (ttl <= 8'd1) begin
                        r.action = ACT_TTL;
                    end else if (find_next_hop(dst, hop)) begin
                        // relay keeps the original sender
                        r.action       = ACT_TRANSMIT;
                        r.out_receiver = hop;
                        r.out_ttl      = ttl - 8'd1;
                    end else begin
                        r.action = ACT_NO_ROUTE;
                    end
                end
            end
            OP_WRITE: begin
                if (int'(eidx) < TABLE_DEPTH) begin
                    route_dst[eidx] = edst;
                    route_hop[eidx] = ehop;
                end
                r.action = ACT_WRITTEN;
            end
            default: r.action = ACT_NOT_US;
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            own_address = OWN_ADDRESS_RST;
            route_ready = 1'b0;
            port_limit  = PORT_LIMIT_RST;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                route_dst[i] = '0;
                route_hop[i] = '0;
            end
            expected_decisions.delete();
        end else begin
            // result side first: a packet accepted now cannot leave at this edge
            if (m_tvalid && m_tready) begin
                if (expected_decisions.size() == 0) begin
                    $error("result transfer with no packet outstanding: action %0d", m_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_decisions.pop_front();
                    compare_field("action", 8'(want.action), 8'(m_tuser));
                    compare_field("out_receiver", want.out_receiver, m_tdata[7:0]);
                    compare_field("out_snd_addr", want.out_snd_addr, m_tdata[15:8]);
                    compare_field("rewrite_sender", 8'(want.rewrite_sender), 8'(m_tdata[16]));
                    compare_field("out_ttl", want.out_ttl, m_tdata[24:17]);
                    compare_field("zero pad", 8'd0, 8'(m_tdata[31:25]));
                end
            end
            if (cfg_we) begin
                case (reg_index_t'(cfg_index))
                    REG_OWN_ADDRESS: own_address = cfg_wdata;
                    REG_ROUTE_READY: route_ready = cfg_wdata[0];
                    REG_PORT_LIMIT:  port_limit  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_decisions.push_back(forward_item(opcode_t'(s_tuser), s_tdata));
        end
        // count as of this edge, seen by the stimulus at the next one
        decisions_pending <= expected_decisions.size();
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Packet stimulus for the next-hop forwarder: a directed pass over every
// opcode and drop reason, then random phases under several register settings
// with random idle bursts on both channels, a long result hold-off and
// drained pauses. Checking is done by forwarding_checker.
// ----------------------------------------------------------------------------
module tb;
    import nhpf_pkg::*;

    localparam int STALL_LIMIT = 1000;

    typedef struct {
        opcode_t    op;
        logic [7:0] dst, src, rcv, port, ttl, eidx, edst, ehop;
    } pkt_item_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [IN_TUSER_W-1:0]  s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int mismatch_count;
    int decisions_pending;
    int idle_cycles = 0;

    // stimulus-side copy of the registers, used only to shape packets
    logic [7:0] own_addr = OWN_ADDRESS_RST;
    logic [7:0] port_lim = PORT_LIMIT_RST;

    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b1;
    bit hold_req   = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    next_hop_packet_forwarder_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    forwarding_checker u_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .mismatch_count    (mismatch_count),
        .decisions_pending (decisions_pending)
    );

    // cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: ready, random stall bursts, one long hold-off on request
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (64) @(posedge aclk);
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    function automatic pkt_item_t mk(opcode_t op, logic [7:0] dst, logic [7:0] src,
                                     logic [7:0] rcv, logic [7:0] port, logic [7:0] ttl,
                                     logic [7:0] eidx, logic [7:0] edst, logic [7:0] ehop);
        pkt_item_t it;
        it.op = op;   it.dst = dst;   it.src = src;   it.rcv = rcv;   it.port = port;
        it.ttl = ttl; it.eidx = eidx; it.edst = edst; it.ehop = ehop;
        return it;
    endfunction

    // mostly a small set of addresses so that writes and lookups meet
    function automatic logic [7:0] pick_addr();
        if ($urandom_range(0, 9) < 7)
            return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic pkt_item_t random_item();
        pkt_item_t it;
        int        kind;
        it = mk(OP_RECV, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            it.op   = OP_WRITE;
            it.eidx = pick_addr();
            if ($urandom_range(0, 4) != 0)
                it.edst = it.eidx;
        end else if (kind < 40) begin
            it.op  = OP_SEND;
            it.dst = ($urandom_range(0, 9) == 0) ? BCAST_ADDR : pick_addr();
        end else if (kind < 95) begin
            if (port_lim != 0 && $urandom_range(0, 7) != 0)
                it.port = 8'($urandom_range(0, port_lim - 1));
            if ($urandom_range(0, 9) == 0)
                it.src = own_addr;
            case ($urandom_range(0, 9))
                0:       it.dst = own_addr;
                1:       it.dst = BCAST_ADDR;
                default: it.dst = pick_addr();
            endcase
            if ($urandom_range(0, 3) != 0)
                it.rcv = own_addr;
            if ($urandom_range(0, 4) == 0)
                it.ttl = 8'($urandom_range(0, 2));
        end else begin
            it.op = opcode_t'($urandom_range(0, 3));
        end
        return it;
    endfunction

    task automatic offer(input pkt_item_t it);
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {it.ehop, it.edst, it.eidx, it.ttl, it.port, it.rcv, it.src, it.dst};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (decisions_pending != 0);
    endtask

    task automatic configure(input logic [7:0] own, input logic rdy, input logic [7:0] lim);
        cfg_we    <= 1'b1;
        cfg_index <= REG_OWN_ADDRESS;
        cfg_wdata <= own;
        @(posedge aclk);
        cfg_index <= REG_ROUTE_READY;
        cfg_wdata <= {7'd0, rdy};
        @(posedge aclk);
        cfg_index <= REG_PORT_LIMIT;
        cfg_wdata <= lim;
        @(posedge aclk);
        cfg_index <= REG_UNUSED;
        cfg_wdata <= 8'($urandom);
        @(posedge aclk);
        cfg_we   <= 1'b0;
        own_addr = own;
        port_lim = lim;
    endtask

    // one register setting, then a run of random packets
    task automatic run_phase(input logic [7:0] own, input logic rdy, input logic [7:0] lim,
                             input int len, input bit with_hold);
        wait_drained();
        configure(own, rdy, lim);
        for (int i = 0; i < len; i++) begin
            if (with_hold && i == len / 2)
                hold_req = 1'b1;
            offer(random_item());
            if (tx_idle_en && $urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 7));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values: own address 1, table not usable, port limit 16
        offer(mk(OP_SEND,  8'd0, 8'd9, 8'd9, 8'd3,  8'd20, 8'd0, 8'd0, 8'd0));
        offer(mk(OP_SEND,  8'd5, 8'd9, 8'd9, 8'd3,  8'd20, 8'd0, 8'd0, 8'd0));
        offer(mk(OP_WRITE, 8'd0, 8'd0, 8'd0, 8'd0,  8'd0,  8'd5, 8'd5, 8'd9));
        offer(mk(OP_SEND,  8'd5, 8'd9, 8'd9, 8'd3,  8'd20, 8'd0, 8'd0, 8'd0));
        offer(mk(OP_RECV,  8'd2, 8'd3, 8'd1, 8'd16, 8'd5,  8'd0, 8'd0, 8'd0));
        offer(mk(OP_RECV,  8'd2, 8'd1, 8'd1, 8'd3,  8'd5,  8'd0, 8'd0, 8'd0));
        offer(mk(OP_RECV,  8'd1, 8'd3, 8'd4, 8'd3,  8'd5,  8'd0, 8'd0, 8'd0));
        offer(mk(OP_RECV,  8'd0, 8'd3, 8'd4, 8'd3,  8'd5,  8'd0, 8'd0, 8'd0));
        offer(mk(OP_RECV,  8'd5, 8'd3, 8'd1, 8'd3,  8'd1,  8'd0, 8'd0, 8'd0));
        offer(mk(OP_RECV,  8'd5, 8'd3, 8'd1, 8'd3,  8'd0,  8'd0, 8'd0, 8'd0));
        offer(mk(OP_RECV,  8'd5, 8'd3, 8'd1, 8'd3,  8'd4,  8'd0, 8'd0, 8'd0));
        offer(mk(OP_RECV,  8'd5, 8'd3, 8'd6, 8'd3,  8'd4,  8'd0, 8'd0, 8'd0));
        offer(mk(OP_NONE,  8'd5, 8'd3, 8'd1, 8'd3,  8'd4,  8'd5, 8'd5, 8'd9));
        wait_drained();

        // table usable: hits, a mismatched entry, the top slot, an unwritten slot
        configure(8'd1, 1'b1, 8'd16);
        offer(mk(OP_SEND,  8'd5,   8'd9, 8'd9, 8'd3,  8'd20,  8'd0,   8'd0,   8'd0));
        offer(mk(OP_RECV,  8'd5,   8'd3, 8'd1, 8'd3,  8'd4,   8'd0,   8'd0,   8'd0));
        offer(mk(OP_WRITE, 8'd0,   8'd0, 8'd0, 8'd0,  8'd0,   8'd6,   8'd7,   8'd8));
        offer(mk(OP_SEND,  8'd6,   8'd9, 8'd9, 8'd3,  8'd20,  8'd0,   8'd0,   8'd0));
        offer(mk(OP_WRITE, 8'd0,   8'd0, 8'd0, 8'd0,  8'd0,   8'd255, 8'd255, 8'd42));
        offer(mk(OP_SEND,  8'd255, 8'd9, 8'd9, 8'd3,  8'd20,  8'd0,   8'd0,   8'd0));
        offer(mk(OP_SEND,  8'd200, 8'd9, 8'd9, 8'd3,  8'd20,  8'd0,   8'd0,   8'd0));
        offer(mk(OP_RECV,  8'd255, 8'd3, 8'd1, 8'd15, 8'd255, 8'd0,   8'd0,   8'd0));

        tx_idle_en = 1'b1;
        run_phase(8'd1,   1'b1, 8'd16,  300, 1'b1);
        run_phase(8'd255, 1'b1, 8'd255, 300, 1'b0);
        run_phase(8'd3,   1'b1, 8'd1,   250, 1'b1);
        run_phase(8'd0,   1'b1, 8'd0,   120, 1'b0);
        run_phase(8'd128, 1'b0, 8'd200, 250, 1'b0);

        // closing phase runs with no idle cycles on either side
        wait_drained();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_phase(8'd7,   1'b1, 8'd255, 310, 1'b0);
        wait_drained();

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
